/* rtl/bte_pkg.sv */
`timescale 1ns / 1ps

package bte_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int SAMPLE_FRAC = 20;
  localparam int COEF_W      = 32;
  localparam int GAIN_W      = 32;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 5;
  localparam int MUL_W       = 35;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int WIDE_W      = 72;

  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef enum logic [2:0] {
    REG_OUTPUT_GAIN = 3'd0,
    REG_TREBLE_GAIN = 3'd1,
    REG_BASS_GAIN   = 3'd2,
    REG_TREBLE_A1   = 3'd3,
    REG_TREBLE_A2   = 3'd4,
    REG_BASS_A1     = 3'd5,
    REG_BASS_A2     = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic        [GAIN_W-1:0] output_gain;
    logic        [GAIN_W-1:0] treble_gain;
    logic        [GAIN_W-1:0] bass_gain;
    logic signed [COEF_W-1:0] treble_a1;
    logic signed [COEF_W-1:0] treble_a2;
    logic signed [COEF_W-1:0] bass_a1;
    logic signed [COEF_W-1:0] bass_a2;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic done;
  } lane_stat_t;

  localparam logic signed [31:0] INV_TWO_PI = 32'sd683565276;
  localparam logic signed [31:0] HALF_PI    = 32'sd1686629713;

  // odd sine polynomial, lowest order first
  localparam logic signed [31:0] SIN_C [6] = '{
    32'sd1686629713, -32'sd693598668, 32'sd85569306,
    -32'sd5026995, 32'sd172272, -32'sd3864
  };

  // asin core polynomial in |v|, lowest order first
  localparam logic signed [31:0] ASIN_C [8] = '{
    32'sd1686629690, -32'sd230423709, 32'sd95540460, -32'sd53874250,
    32'sd33169908, -32'sd18348235, 32'sd7161955, -32'sd1355590
  };

  // round half up, then arithmetic shift
  function automatic wide_t rshr(input wide_t p, input int unsigned k);
    wide_t half;
    half = wide_t'(1) <<< (k - 1);
    return (p + half) >>> k;
  endfunction

  function automatic logic signed [31:0] sat32(input wide_t v);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< 31) - wide_t'(1);
    lo = -(wide_t'(1) <<< 31);
    if (v > hi) begin
      return hi[31:0];
    end else if (v < lo) begin
      return lo[31:0];
    end
    return v[31:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input wide_t v);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (SAMPLE_W - 1)) - wide_t'(1);
    lo = -(wide_t'(1) <<< (SAMPLE_W - 1));
    if (v > hi) begin
      return hi[SAMPLE_W-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_W-1:0];
    end
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

/* rtl/bte_in_if.sv */
`timescale 1ns / 1ps

interface bte_in_if import bte_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

/* rtl/bte_out_if.sv */
`timescale 1ns / 1ps

interface bte_out_if import bte_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_result;
  logic signed [SAMPLE_W-1:0] right_result;

  modport source (output valid, output left_result, output right_result, input ready);
  modport sink (input valid, input left_result, input right_result, output ready);
endinterface

/* rtl/bte_regs.sv */
`timescale 1ns / 1ps

module bte_regs import bte_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_OUTPUT_GAIN: cfg_d.output_gain = pwdata;
        REG_TREBLE_GAIN: cfg_d.treble_gain = pwdata;
        REG_BASS_GAIN:   cfg_d.bass_gain   = pwdata;
        REG_TREBLE_A1:   cfg_d.treble_a1   = signed'(pwdata);
        REG_TREBLE_A2:   cfg_d.treble_a2   = signed'(pwdata);
        REG_BASS_A1:     cfg_d.bass_a1     = signed'(pwdata);
        REG_BASS_A2:     cfg_d.bass_a2     = signed'(pwdata);
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_OUTPUT_GAIN: prdata = cfg_q.output_gain;
      REG_TREBLE_GAIN: prdata = cfg_q.treble_gain;
      REG_BASS_GAIN:   prdata = cfg_q.bass_gain;
      REG_TREBLE_A1:   prdata = cfg_q.treble_a1;
      REG_TREBLE_A2:   prdata = cfg_q.treble_a2;
      REG_BASS_A1:     prdata = cfg_q.bass_a1;
      REG_BASS_A2:     prdata = cfg_q.bass_a2;
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.output_gain <= 32'h1000_0000;
      cfg_q.treble_gain <= 32'h1000_0000;
      cfg_q.bass_gain   <= 32'h1000_0000;
      cfg_q.treble_a1   <= -32'sd1001479000;
      cfg_q.treble_a2   <= 32'sd164176925;
      cfg_q.bass_a1     <= -32'sd196506000;
      cfg_q.bass_a2     <= -32'sd437969000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* rtl/bte_lane.sv */
`timescale 1ns / 1ps

module bte_lane import bte_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       bank_i,
  input  logic                       ack_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  cfg_t                       cfg_i,
  output lane_stat_t                 stat_o,
  output logic signed [SAMPLE_W-1:0] result_o
);

  typedef enum logic [24:0] {
    S_IDLE = 25'd1,       S_TRIM = 25'd2,       S_GAIN = 25'd4,
    S_PHI  = 25'd8,       S_QUAD = 25'd16,      S_USQ  = 25'd32,
    S_U2   = 25'd64,      S_HMUL = 25'd128,     S_HADD = 25'd256,
    S_SMUL = 25'd512,     S_SOUT = 25'd1024,    S_F0   = 25'd2048,
    S_F1   = 25'd4096,    S_F2   = 25'd8192,    S_F3   = 25'd16384,
    S_F4   = 25'd32768,   S_TMUL = 25'd65536,   S_TADD = 25'd131072,
    S_BADD = 25'd262144,  S_AMUL = 25'd524288,  S_AADD = 25'd1048576,
    S_SQRT = 25'd2097152, S_QMUL = 25'd4194304, S_AOUT = 25'd8388608,
    S_DONE = 25'd16777216
  } state_e;

  state_e state_q, state_d;

  logic signed [SAMPLE_W-1:0] x_q, x_d;
  logic                       bank_q, bank_d;
  logic signed [32:0]         g_q, g_d;
  logic        [1:0]          quad_q, quad_d;
  logic        [30:0]         u_q, u_d;
  logic        [30:0]         u2_q, u2_d;
  logic signed [33:0]         acc_q, acc_d;
  logic        [2:0]          cnt_q, cnt_d;
  logic signed [31:0]         x28_q, x28_d;
  logic                       flt_q, flt_d;
  logic signed [PROD_W-1:0]   bx_q, bx_d;
  logic signed [31:0]         y_q, y_d;
  logic signed [31:0]         nd0_q, nd0_d;
  logic signed [31:0]         tr_q, tr_d;
  logic signed [31:0]         yb_q, yb_d;
  logic signed [39:0]         mix_q, mix_d;
  logic                       neg_q, neg_d;
  logic        [60:0]         rem_q, rem_d;
  logic        [61:0]         root_q, root_d;
  logic        [61:0]         bit_q, bit_d;
  logic signed [SAMPLE_W-1:0] res_q, res_d;
  logic signed [PROD_W-1:0]   p_q;

  logic signed [31:0] d0_q [2][2];
  logic signed [31:0] d1_q [2][2];

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [COEF_W-1:0] a1, a2;
  logic signed [MUL_W-1:0] b0;
  logic signed [31:0] d0_cur, d1_cur;
  wide_t p_w, rs24, rs28, rs30;
  logic [31:0] phase;
  logic [30:0] u_frac;
  wide_t sin_s;
  logic signed [31:0] y_f1, nd0_w, nd1_w;
  wide_t mix_sum, mix_clip, mix_abs;
  logic [61:0] trial;
  logic [61:0] rem_ext;
  wide_t asin_res;

  assign a1     = flt_q ? cfg_i.bass_a1 : cfg_i.treble_a1;
  assign a2     = flt_q ? cfg_i.bass_a2 : cfg_i.treble_a2;
  assign b0     = MUL_W'(rshr((wide_t'(1) <<< 30) + wide_t'(a1) + wide_t'(a2), 2));
  assign d0_cur = d0_q[flt_q][bank_q];
  assign d1_cur = d1_q[flt_q][bank_q];

  assign p_w  = wide_t'(p_q);
  assign rs24 = rshr(p_w, 24);
  assign rs28 = rshr(p_w, 28);
  assign rs30 = rshr(p_w, 30);

  // turn fraction out of the phase product, mirrored in odd quadrants
  assign phase  = p_q[55:24];
  assign u_frac = phase[30] ? (31'h4000_0000 - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
  assign sin_s  = quad_q[1] ? -rs30 : rs30;

  assign y_f1  = sat32(rshr(p_w + (wide_t'(d0_cur) <<< 30), 30));
  assign nd0_w = sat32(rshr((wide_t'(bx_q) <<< 1) - p_w + (wide_t'(d1_cur) <<< 30), 30));
  assign nd1_w = sat32(rshr(wide_t'(bx_q) - p_w, 30));

  assign mix_sum  = wide_t'(mix_q) + rs28;
  assign mix_clip = (mix_sum > (wide_t'(1) <<< 28)) ? (wide_t'(1) <<< 28) :
                    (mix_sum < -(wide_t'(1) <<< 28)) ? -(wide_t'(1) <<< 28) : mix_sum;
  assign mix_abs  = (mix_clip < 0) ? -mix_clip : mix_clip;

  assign trial    = root_q + bit_q;
  assign rem_ext  = {1'b0, rem_q};
  assign asin_res = neg_q ? -(wide_t'(HALF_PI) - rs30) : (wide_t'(HALF_PI) - rs30);

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    bank_d  = bank_q;
    g_d     = g_q;
    quad_d  = quad_q;
    u_d     = u_q;
    u2_d    = u2_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    x28_d   = x28_q;
    flt_d   = flt_q;
    bx_d    = bx_q;
    y_d     = y_q;
    nd0_d   = nd0_q;
    tr_d    = tr_q;
    yb_d    = yb_q;
    mix_d   = mix_q;
    neg_d   = neg_q;
    rem_d   = rem_q;
    root_d  = root_q;
    bit_d   = bit_q;
    res_d   = res_q;
    mul_a   = '0;
    mul_b   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          x_d     = sample_i;
          bank_d  = bank_i;
          state_d = S_TRIM;
        end
      end
      S_TRIM: begin
        mul_a   = MUL_W'(x_q);
        mul_b   = signed'(MUL_W'(cfg_i.output_gain));
        state_d = S_GAIN;
      end
      S_GAIN: begin
        g_d     = 33'(rs24);
        state_d = S_PHI;
      end
      S_PHI: begin
        mul_a   = MUL_W'(g_q);
        mul_b   = MUL_W'(INV_TWO_PI);
        state_d = S_QUAD;
      end
      S_QUAD: begin
        quad_d  = phase[31:30];
        u_d     = u_frac;
        state_d = S_USQ;
      end
      S_USQ: begin
        mul_a   = signed'(MUL_W'(u_q));
        mul_b   = signed'(MUL_W'(u_q));
        state_d = S_U2;
      end
      S_U2: begin
        u2_d    = 31'(rs30);
        acc_d   = 34'(SIN_C[5]);
        cnt_d   = 3'd4;
        state_d = S_HMUL;
      end
      S_HMUL: begin
        mul_a   = MUL_W'(acc_q);
        mul_b   = signed'(MUL_W'(u2_q));
        state_d = S_HADD;
      end
      S_HADD: begin
        acc_d = 34'(wide_t'(SIN_C[cnt_q]) + rs30);
        if (cnt_q == 3'd0) begin
          state_d = S_SMUL;
        end else begin
          cnt_d   = cnt_q - 3'd1;
          state_d = S_HMUL;
        end
      end
      S_SMUL: begin
        mul_a   = MUL_W'(acc_q);
        mul_b   = signed'(MUL_W'(u_q));
        state_d = S_SOUT;
      end
      S_SOUT: begin
        x28_d   = 32'(rshr(sin_s, 2));
        flt_d   = 1'b0;
        state_d = S_F0;
      end
      S_F0: begin
        mul_a   = b0;
        mul_b   = MUL_W'(x28_q);
        state_d = S_F1;
      end
      S_F1: begin
        bx_d    = p_q;
        y_d     = y_f1;
        state_d = S_F2;
      end
      S_F2: begin
        mul_a   = MUL_W'(a1);
        mul_b   = MUL_W'(y_q);
        state_d = S_F3;
      end
      S_F3: begin
        nd0_d   = nd0_w;
        mul_a   = MUL_W'(a2);
        mul_b   = MUL_W'(y_q);
        state_d = S_F4;
      end
      S_F4: begin
        if (!flt_q) begin
          tr_d    = sat32(wide_t'(x28_q) - wide_t'(y_q));
          flt_d   = 1'b1;
          state_d = S_F0;
        end else begin
          yb_d    = y_q;
          state_d = S_TMUL;
        end
      end
      S_TMUL: begin
        mul_a   = MUL_W'(tr_q);
        mul_b   = signed'(MUL_W'(cfg_i.treble_gain));
        state_d = S_TADD;
      end
      S_TADD: begin
        mix_d   = 40'(rs28);
        mul_a   = MUL_W'(yb_q);
        mul_b   = signed'(MUL_W'(cfg_i.bass_gain));
        state_d = S_BADD;
      end
      S_BADD: begin
        neg_d   = mix_clip < 0;
        u_d     = 31'(mix_abs <<< 2);
        acc_d   = 34'(ASIN_C[7]);
        cnt_d   = 3'd6;
        state_d = S_AMUL;
      end
      S_AMUL: begin
        mul_a   = MUL_W'(acc_q);
        mul_b   = signed'(MUL_W'(u_q));
        state_d = S_AADD;
      end
      S_AADD: begin
        acc_d = 34'(wide_t'(ASIN_C[cnt_q]) + rs30);
        if (cnt_q == 3'd0) begin
          rem_d   = {31'h4000_0000 - u_q, 30'b0};
          root_d  = '0;
          bit_d   = 62'(1) << 60;
          state_d = S_SQRT;
        end else begin
          cnt_d   = cnt_q - 3'd1;
          state_d = S_AMUL;
        end
      end
      S_SQRT: begin
        // restoring square root, one result bit per cycle
        if (bit_q != '0) begin
          if (rem_ext >= trial) begin
            rem_d  = 61'(rem_ext - trial);
            root_d = (root_q >> 1) + bit_q;
          end else begin
            root_d = root_q >> 1;
          end
          bit_d = bit_q >> 2;
        end else begin
          state_d = S_QMUL;
        end
      end
      S_QMUL: begin
        mul_a   = signed'(MUL_W'(root_q[30:0]));
        mul_b   = MUL_W'(acc_q);
        state_d = S_AOUT;
      end
      S_AOUT: begin
        res_d   = sat_sample(rshr(asin_res, 30 - SAMPLE_FRAC));
        state_d = S_DONE;
      end
      S_DONE: begin
        if (ack_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int f = 0; f < 2; f++) begin
        for (int b = 0; b < 2; b++) begin
          d0_q[f][b] <= '0;
          d1_q[f][b] <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_F4) begin
        d0_q[flt_q][bank_q] <= nd0_q;
        d1_q[flt_q][bank_q] <= nd1_w;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= mul_a * mul_b;
    x_q    <= x_d;
    bank_q <= bank_d;
    g_q    <= g_d;
    quad_q <= quad_d;
    u_q    <= u_d;
    u2_q   <= u2_d;
    acc_q  <= acc_d;
    cnt_q  <= cnt_d;
    x28_q  <= x28_d;
    flt_q  <= flt_d;
    bx_q   <= bx_d;
    y_q    <= y_d;
    nd0_q  <= nd0_d;
    tr_q   <= tr_d;
    yb_q   <= yb_d;
    mix_q  <= mix_d;
    neg_q  <= neg_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    res_q  <= res_d;
  end

  assign stat_o.idle = (state_q == S_IDLE);
  assign stat_o.done = (state_q == S_DONE);
  assign result_o    = res_q;

endmodule

/* rtl/bte_merge.sv */
`timescale 1ns / 1ps

module bte_merge import bte_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lane_stat_t                 stat_l_i,
  input  lane_stat_t                 stat_r_i,
  input  logic signed [SAMPLE_W-1:0] left_i,
  input  logic signed [SAMPLE_W-1:0] right_i,
  output logic                       ack_o,
  bte_out_if.source                  out_o
);

  logic                       valid_q, valid_d;
  logic signed [SAMPLE_W-1:0] left_q, right_q;
  logic                       load;

  // both lanes finish together; take the pair once the output slot frees
  assign load  = stat_l_i.done & stat_r_i.done & (~valid_q | out_o.ready);
  assign ack_o = load;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      left_q  <= left_i;
      right_q <= right_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.left_result  = left_q;
  assign out_o.right_result = right_q;

endmodule

/* rtl/stereo_baxandall_tone_eq.sv */
`timescale 1ns / 1ps

// Stereo tone control: each channel is trimmed, sine shaped, split by two
// lowpass biquads (treble and bass), the bands are weighted, summed, clipped
// and asin shaped. Left and right run in two identical lanes side by side,
// each built around one 35x35 multiplier that a sequencer steps through the
// dependent product chain (trim, phase, sine and asin polynomials, filters,
// band gains), followed by a 31-step restoring square root. A new pair is
// taken only once both lanes are idle, so a lane finishes and hands off one
// pair before it takes the next; a finished pair waits in the output register
// while the next one is processed. The biquad delay state keeps two banks
// that alternate on every pair. Registers sit on the APB port at byte
// address 4*i: output_gain, treble_gain, bass_gain, treble_pole_a1,
// treble_pole_a2, bass_pole_a1, bass_pole_a2.
module stereo_baxandall_tone_eq import bte_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  bte_in_if.sink            in_i,
  bte_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t                       cfg;
  lane_stat_t                 stat_l, stat_r;
  logic signed [SAMPLE_W-1:0] res_l, res_r;
  logic                       lane_ack;
  logic                       in_fire;
  logic                       bank_q, bank_d;

  assign in_i.ready = stat_l.idle & stat_r.idle;
  assign in_fire    = in_i.valid & in_i.ready;
  assign bank_d     = in_fire ? ~bank_q : bank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= 1'b0;
    end else begin
      bank_q <= bank_d;
    end
  end

  bte_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bte_lane u_lane_l (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_fire),
    .bank_i   (bank_q),
    .ack_i    (lane_ack),
    .sample_i (in_i.left_sample),
    .cfg_i    (cfg),
    .stat_o   (stat_l),
    .result_o (res_l)
  );

  bte_lane u_lane_r (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_fire),
    .bank_i   (bank_q),
    .ack_i    (lane_ack),
    .sample_i (in_i.right_sample),
    .cfg_i    (cfg),
    .stat_o   (stat_r),
    .result_o (res_r)
  );

  bte_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stat_l_i (stat_l),
    .stat_r_i (stat_r),
    .left_i   (res_l),
    .right_i  (res_r),
    .ack_o    (lane_ack),
    .out_o    (out_o)
  );

  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_l == stat_r)
    else $error("lanes out of step");

  a_bank_flips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> bank_q != $past(bank_q))
    else $error("delay bank did not alternate");

  a_out_from_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(lane_ack))
    else $error("output valid without lane results");

endmodule

/* tb/sv/tb_stereo_baxandall_tone_eq.sv */
`timescale 1ns / 1ps

module tb_stereo_baxandall_tone_eq;
  import bte_pkg::*;

  typedef logic signed [79:0] w_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } pair_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    bit                         typed;
    logic signed [SAMPLE_W-1:0] exp_left;
    logic signed [SAMPLE_W-1:0] exp_right;
  } row_t;

  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 180;
  localparam int NUM_PHASES   = 8;
  localparam int UNMAPPED_REG = 7;
  localparam logic [31:0] UNITY_GAIN = 32'h1000_0000;
  localparam logic [31:0] RST_TA1 = 32'(-1001479000);
  localparam logic [31:0] RST_TA2 = 32'd164176925;
  localparam logic [31:0] RST_BA1 = 32'(-196506000);
  localparam logic [31:0] RST_BA2 = 32'(-437969000);
  localparam longint SINE_K [6] = '{
    1686629713, -693598668, 85569306, -5026995, 172272, -3864
  };
  localparam longint ASIN_K [8] = '{
    1686629690, -230423709, 95540460, -53874250,
    33169908, -18348235, 7161955, -1355590
  };
  localparam longint QUARTER_PI2 = 1686629713;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  bte_in_if  in_if ();
  bte_out_if out_if ();

  stereo_baxandall_tone_eq uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk_i = ~clk_i;

  // shadow of the block's registers and filter state
  logic [31:0]        regs_q [7];
  logic signed [31:0] treble_dl [2][4];
  logic signed [31:0] bass_dl [2][4];
  bit                 bank_sel;

  pair_t eq_pending [$];
  int    errors = 0;
  int    stall_cnt = 0;
  bit    idle_en = 1'b1;
  bit    hold_req = 1'b0;

  function automatic w_t rnd(w_t p, int k);
    return (p + (w_t'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic w_t clip(w_t v, w_t lo, w_t hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic w_t s32(w_t v);
    return clip(v, -(w_t'(1) <<< 31), (w_t'(1) <<< 31) - 1);
  endfunction

  function automatic w_t sine_turn(logic [31:0] p);
    w_t u, u2, acc, s;
    u = p[29:0];
    if (p[30]) begin
      u = (w_t'(1) <<< 30) - u;
    end
    u2 = rnd(u * u, 30);
    acc = SINE_K[5];
    for (int i = 4; i >= 0; i--) begin
      acc = w_t'(SINE_K[i]) + rnd(acc * u2, 30);
    end
    s = rnd(acc * u, 30);
    return p[31] ? -s : s;
  endfunction

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic w_t arcsine(w_t v);
    w_t a, u, acc, sq, t, res;
    a = v < 0 ? -v : v;
    u = a * 4;
    acc = ASIN_K[7];
    for (int i = 6; i >= 0; i--) begin
      acc = w_t'(ASIN_K[i]) + rnd(acc * u, 30);
    end
    t = ((w_t'(1) <<< 30) - u) <<< 30;
    sq = int_root(t[63:0]);
    res = w_t'(QUARTER_PI2) - rnd(sq * acc, 30);
    return v < 0 ? -res : res;
  endfunction

  function automatic w_t biquad(inout logic signed [31:0] d0, inout logic signed [31:0] d1,
                                input w_t a1, input w_t a2, input w_t x);
    w_t one, b0, b1, y, e0, e1, t;
    one = w_t'(1) <<< 30;
    e0 = d0;
    e1 = d1;
    b0 = rnd(one + a1 + a2, 2);
    b1 = 2 * b0;
    y = s32(rnd(b0 * x + e0 * one, 30));
    t = s32(rnd(b1 * x - a1 * y + e1 * one, 30));
    d0 = t[31:0];
    t = s32(rnd(b0 * x - a2 * y, 30));
    d1 = t[31:0];
    return y;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] eq_lane(logic signed [SAMPLE_W-1:0] s,
                                                         int ch, int o);
    w_t x, og, g, pr, x28, yt, yb, tr, mix, r;
    w_t ta1, ta2, ba1, ba2, tg, bg;
    og = regs_q[REG_OUTPUT_GAIN];
    tg = regs_q[REG_TREBLE_GAIN];
    bg = regs_q[REG_BASS_GAIN];
    ta1 = $signed(regs_q[REG_TREBLE_A1]);
    ta2 = $signed(regs_q[REG_TREBLE_A2]);
    ba1 = $signed(regs_q[REG_BASS_A1]);
    ba2 = $signed(regs_q[REG_BASS_A2]);
    x = s;
    g = rnd(x * og, 24);
    pr = g * w_t'(683565276);
    x28 = rnd(sine_turn(pr[55:24]), 2);
    yt = biquad(treble_dl[ch][o], treble_dl[ch][o+1], ta1, ta2, x28);
    yb = biquad(bass_dl[ch][o], bass_dl[ch][o+1], ba1, ba2, x28);
    tr = s32(x28 - yt);
    mix = rnd(tr * tg, 28) + rnd(yb * bg, 28);
    mix = clip(mix, -(w_t'(1) <<< 28), w_t'(1) <<< 28);
    r = rnd(arcsine(mix), 10);
    r = clip(r, -(w_t'(1) <<< (SAMPLE_W - 1)), (w_t'(1) <<< (SAMPLE_W - 1)) - 1);
    return r[SAMPLE_W-1:0];
  endfunction

  function automatic pair_t eq_predict(logic signed [SAMPLE_W-1:0] l,
                                       logic signed [SAMPLE_W-1:0] r);
    pair_t p;
    int o;
    o = bank_sel ? 2 : 0;
    p.left = eq_lane(l, 0, o);
    p.right = eq_lane(r, 1, o);
    bank_sel = ~bank_sel;
    return p;
  endfunction

  task automatic reg_write(int idx, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 4);
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx <= int'(REG_BASS_A2)) begin
      regs_q[idx] = v;
    end
    @(posedge clk_i);
  endtask

  task automatic send_pair(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r,
                           bit typed, logic signed [SAMPLE_W-1:0] el,
                           logic signed [SAMPLE_W-1:0] er);
    pair_t p;
    in_if.valid <= 1'b1;
    in_if.left_sample <= l;
    in_if.right_sample <= r;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    p = eq_predict(l, r);
    if (typed) begin
      p.left = el;
      p.right = er;
    end
    eq_pending.push_back(p);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (eq_pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return SAMPLE_W'($urandom);
      4, 5:       return SAMPLE_W'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      6:          return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default:    return $urandom_range(0, 1) ? 24'h100000 : 24'hF00000;
    endcase
  endfunction

  task automatic load_setting(int ph);
    logic [31:0] v [7];
    case (ph)
      1: begin
        foreach (v[i]) v[i] = $urandom;
      end
      2: begin
        v = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      end
      3: begin
        v = '{32'h0, 32'h0, 32'h0,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      end
      4: begin
        v = '{32'hFFFF_FFFF, 32'h0, UNITY_GAIN, RST_TA1, RST_TA2, RST_BA1, RST_BA2};
      end
      5: begin
        v = '{$urandom_range(0, 2 * UNITY_GAIN), $urandom_range(0, 4 * UNITY_GAIN),
              $urandom_range(0, 4 * UNITY_GAIN), 32'h0, 32'h0, 32'h0, 32'h0};
      end
      default: begin
        v = '{$urandom_range(0, 2 * UNITY_GAIN), $urandom_range(0, 4 * UNITY_GAIN),
              $urandom_range(0, 4 * UNITY_GAIN), RST_TA1, RST_TA2, RST_BA1, RST_BA2};
      end
    endcase
    foreach (v[i]) reg_write(i, v[i]);
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // result checker and watchdog
  always @(posedge clk_i) begin
    pair_t e;
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cnt <= 0;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
      if (stall_cnt >= STALL_LIMIT) begin
        $display("tb_stereo_baxandall_tone_eq failed");
        $finish;
      end
      if (out_if.valid && out_if.ready) begin
        if (eq_pending.size() == 0) begin
          $error("unexpected transfer: left_result %0d right_result %0d",
                 out_if.left_result, out_if.right_result);
          errors++;
        end else begin
          e = eq_pending.pop_front();
          if (out_if.left_result !== e.left) begin
            $error("left_result expected %0d got %0d", e.left, out_if.left_result);
            errors++;
          end
          if (out_if.right_result !== e.right) begin
            $error("right_result expected %0d got %0d", e.right, out_if.right_result);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    row_t rows [$];
    in_if.valid <= 1'b0;
    in_if.left_sample <= '0;
    in_if.right_sample <= '0;
    regs_q = '{UNITY_GAIN, UNITY_GAIN, UNITY_GAIN, RST_TA1, RST_TA2, RST_BA1, RST_BA2};
    treble_dl = '{default: '{default: '0}};
    bass_dl = '{default: '{default: '0}};
    bank_sel = 1'b0;

    // silence through a fresh block comes out as zero; other rows use predicted values
    rows = '{
      '{24'sh000000, 24'sh000000, 1'b1, 24'sh0, 24'sh0},
      '{24'sh000000, 24'sh000000, 1'b1, 24'sh0, 24'sh0},
      '{24'sh7FFFFF, 24'sh800000, 1'b0, 24'sh0, 24'sh0},
      '{24'sh800000, 24'sh7FFFFF, 1'b0, 24'sh0, 24'sh0},
      '{24'sh000001, 24'shFFFFFF, 1'b0, 24'sh0, 24'sh0},
      '{24'shFFFFFF, 24'sh000001, 1'b0, 24'sh0, 24'sh0},
      '{24'sh555555, 24'shAAAAAA, 1'b0, 24'sh0, 24'sh0},
      '{24'shAAAAAA, 24'sh555555, 1'b0, 24'sh0, 24'sh0},
      '{24'sh100000, 24'shF00000, 1'b0, 24'sh0, 24'sh0},
      '{24'sh3243F6, 24'shCDBC0A, 1'b0, 24'sh0, 24'sh0},
      '{24'sh7FFFFF, 24'sh7FFFFF, 1'b0, 24'sh0, 24'sh0},
      '{24'sh800000, 24'sh800000, 1'b0, 24'sh0, 24'sh0},
      '{24'sh000000, 24'sh000000, 1'b0, 24'sh0, 24'sh0},
      '{24'sh080000, 24'shF80000, 1'b0, 24'sh0, 24'sh0},
      '{24'sh000000, 24'sh7FFFFF, 1'b0, 24'sh0, 24'sh0},
      '{24'sh123456, 24'shEDCBA9, 1'b0, 24'sh0, 24'sh0}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      send_pair(rows[i].left, rows[i].right, rows[i].typed,
                rows[i].exp_left, rows[i].exp_right);
    end
    wait_drained();
    // writes to the unused address must not disturb anything
    reg_write(UNMAPPED_REG, $urandom);
    // max gains overdrive the band sum, forcing the clip before asin
    reg_write(REG_TREBLE_GAIN, 32'hFFFF_FFFF);
    reg_write(REG_BASS_GAIN, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send_pair(pick_sample(), pick_sample(), 1'b0, '0, '0);

    for (int ph = 1; ph <= NUM_PHASES; ph++) begin
      wait_drained();
      idle_en = (ph != 6) && (ph != NUM_PHASES);
      load_setting(ph);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 7 && n == 20) begin
          hold_req = 1'b1;
        end
        if (ph == 7 && n == 100) begin
          wait_drained();
        end
        if (idle_en && $urandom_range(0, 4) == 0) begin
          in_if.valid <= 1'b0;
          repeat ($urandom_range(1, 19)) @(posedge clk_i);
        end
        send_pair(pick_sample(), pick_sample(), 1'b0, '0, '0);
      end
    end

    in_if.valid <= 1'b0;
    while (eq_pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_stereo_baxandall_tone_eq passed");
    end else begin
      $display("tb_stereo_baxandall_tone_eq failed");
    end
    $finish;
  end

endmodule
